// File: rtl/core/tlps_pkg.sv
// Shared types, constants and codes of the two-level priority scheduler.
`default_nettype none
package tlps_pkg;
    localparam int unsigned MaxTasksDef  = 8;
    localparam int unsigned ThreshReset  = 10;
    localparam int unsigned WaitMax      = 255;

    localparam logic       REQ_ADD   = 1'b0;
    localparam logic       REQ_SCHED = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPRI = 2'd1;
    localparam logic [1:0] ST_QUEUED = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [2:0] task_id;
        logic [1:0] priority_req;
        logic       old_valid;
    } t_in_word;

    typedef struct packed {
        logic [2:0] next_task;
        logic       next_valid;
        logic [1:0] status;
        logic [3:0] boosted_count;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the request
        logic start;    // do the add, or the empty schedule, or the pop
        logic age;      // examine one low-queue entry
        logic finish;   // merge boosted tasks, requeue the old task
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic simple;   // request completes at start
        logic age_done; // every low entry has been examined
    } t_stat;
endpackage
`default_nettype wire

// File: rtl/core/tlps_if.sv
// Valid/ready channel that carries one word of type T.
`default_nettype none
interface tlps_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/two_level_priority_scheduler_aging_unit.sv
// Top level of the two-level priority scheduler with aging.
//  channel | dir | handshake   | word
//  in_ch   | in  | valid/ready | req_type, task_id, priority_req, old_valid
//  out_ch  | out | valid/ready | next_task, next_valid, status, boosted_count
//  cfg     | in  | i_cfg_we    | boost threshold (8 bits)
// An add or an empty schedule goes from start straight to the result; a schedule
// pops, then walks the low queue left after the pop and merges; the aging walk
// examines one low entry per cycle. One request is in flight at a time.
// The result word holds until taken. Reset is synchronous and clears queues.
`default_nettype none
module two_level_priority_scheduler_aging_unit #(
    parameter int unsigned MAX_TASKS = tlps_pkg::MaxTasksDef
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [7:0]  i_cfg_data,
    tlps_if.sink       in_ch,
    tlps_if.source     out_ch
);
    import tlps_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    tlps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tlps_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_word    (in_ch.data),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_word    (out_ch.data)
    );
endmodule
`default_nettype wire

// File: rtl/core/tlps_ctrl.sv
// Controller state machine of the scheduler.
`default_nettype none
module tlps_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  wire tlps_pkg::t_stat i_stat,
    output tlps_pkg::t_cmd      o_cmd
);
    import tlps_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_AGE   = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = i_stat.simple ? S_OUT : S_AGE;
            end
            S_AGE: begin
                if (i_stat.age_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.age = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/tlps_dp.sv
// Datapath of the scheduler: queues, per-task state and aging walk.
`default_nettype none
module tlps_dp #(
    parameter int unsigned MAX_TASKS = tlps_pkg::MaxTasksDef
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [7:0]            i_cfg_data,
    input  wire tlps_pkg::t_in_word i_word,
    input  wire tlps_pkg::t_cmd  i_cmd,
    output tlps_pkg::t_stat      o_stat,
    output tlps_pkg::t_out_word  o_word
);
    import tlps_pkg::*;

    localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int unsigned CW = $clog2(MAX_TASKS + 1);

    logic [7:0]    r_thresh;
    logic [IW-1:0] r_hq [MAX_TASKS];
    logic [IW-1:0] r_lq [MAX_TASKS];
    logic [IW-1:0] r_bq [MAX_TASKS];   // boosted tasks in walk order
    logic [IW-1:0] r_kq [MAX_TASKS];   // kept low tasks in walk order
    logic [CW-1:0] r_hc, r_lc, r_bc, r_kc, r_ai;
    logic [7:0]    r_wait [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_boost, r_base, r_qd;
    logic [IW-1:0] r_id;
    logic [2:0]    r_raw;
    logic          r_req, r_oldv, r_requeue;
    logic [1:0]    r_prio;
    t_out_word     r_out;

    logic [IW-1:0] w_id, w_aid, w_next;
    logic [7:0]    w_wb;
    logic          w_empty;
    t_out_word     w_start_out;

    // Task ids wrap to the task count; with two or more tasks a 3-bit id needs at most three subtractions.
    function automatic logic [IW-1:0] wrap_id(input logic [2:0] raw);
        logic [7:0] v;
        v = 8'(raw);
        for (int s = 0; s < 4; s++) begin
            if (v >= 8'(MAX_TASKS)) begin
                v = v - 8'(MAX_TASKS);
            end
        end
        return IW'(v);
    endfunction

    assign w_id    = wrap_id(i_word.task_id);
    assign w_empty = (r_hc == '0) && (r_lc == '0);
    assign w_aid   = r_lq[r_ai[IW-1:0]];
    assign w_wb    = r_wait[w_aid];
    assign w_next  = (r_hc != '0) ? r_hq[0] : r_lq[0];

    assign o_stat.simple   = (r_req == REQ_ADD) || w_empty;
    assign o_stat.age_done = (r_ai >= r_lc);
    assign o_word          = r_out;

    always_comb begin
        w_start_out = '0;
        if (r_req == REQ_ADD) begin
            if (r_prio > 2'd1) begin
                w_start_out.status = ST_BADPRI;
            end else if (r_qd[r_id]) begin
                w_start_out.status = ST_QUEUED;
            end
        end else if (w_empty) begin
            w_start_out.next_task  = r_raw;
            w_start_out.next_valid = r_oldv;
        end else begin
            w_start_out.status     = (r_oldv && r_qd[r_id]) ? ST_QUEUED : ST_OK;
            w_start_out.next_task  = 3'(w_next);
            w_start_out.next_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= 8'(ThreshReset);
            r_hc     <= '0;
            r_lc     <= '0;
            r_boost  <= '0;
            r_base   <= '0;
            r_qd     <= '0;
            for (int t = 0; t < MAX_TASKS; t++) begin
                r_wait[t] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_req  <= i_word.req_type;
                r_id   <= w_id;
                r_raw  <= i_word.task_id;
                r_prio <= i_word.priority_req;
                r_oldv <= i_word.old_valid;
            end
            if (i_cmd.start) begin
                r_out <= w_start_out;
                r_bc  <= '0;
                r_kc  <= '0;
                r_ai  <= '0;
                if (r_req == REQ_ADD) begin
                    if ((r_prio <= 2'd1) && !r_qd[r_id]) begin
                        r_base[r_id]  <= r_prio[0];
                        r_boost[r_id] <= 1'b0;
                        r_qd[r_id]    <= 1'b1;
                        if (r_prio[0]) begin
                            r_hq[r_hc[IW-1:0]] <= r_id;
                            r_hc <= r_hc + 1'b1;
                        end else begin
                            r_lq[r_lc[IW-1:0]] <= r_id;
                            r_lc <= r_lc + 1'b1;
                        end
                    end
                end else if (!w_empty) begin
                    r_requeue        <= r_oldv && !r_qd[r_id];
                    r_qd[w_next]     <= 1'b0;
                    r_boost[w_next]  <= 1'b0;
                    r_wait[w_next]   <= '0;
                    // Pop by shifting the chosen queue down one place.
                    if (r_hc != '0) begin
                        for (int k = 0; k < MAX_TASKS - 1; k++) begin
                            r_hq[k] <= r_hq[k+1];
                        end
                        r_hc <= r_hc - 1'b1;
                    end else begin
                        for (int k = 0; k < MAX_TASKS - 1; k++) begin
                            r_lq[k] <= r_lq[k+1];
                        end
                        r_lc <= r_lc - 1'b1;
                    end
                end
            end
            if (i_cmd.age) begin
                if (w_wb != 8'(WaitMax)) begin
                    r_wait[w_aid] <= w_wb + 1'b1;
                end
                if (w_wb > r_thresh) begin
                    r_boost[w_aid]       <= 1'b1;
                    r_bq[r_bc[IW-1:0]]   <= w_aid;
                    r_bc                 <= r_bc + 1'b1;
                end else begin
                    r_kq[r_kc[IW-1:0]]   <= w_aid;
                    r_kc                 <= r_kc + 1'b1;
                end
                r_ai <= r_ai + 1'b1;
            end
            if (i_cmd.finish) begin
                // Boosted tasks go ahead of the high queue; total never exceeds
                // the task count, so no clipping is needed.
                for (int k = 0; k < MAX_TASKS; k++) begin
                    if (CW'(k) < r_bc) begin
                        r_hq[k] <= r_bq[k];
                    end else if (CW'(k) < r_bc + r_hc) begin
                        r_hq[k] <= r_hq[IW'(CW'(k) - r_bc)];
                    end else if (r_requeue && (r_boost[r_id] || r_base[r_id])
                                 && CW'(k) == r_bc + r_hc) begin
                        r_hq[k] <= r_id;
                    end
                    if (CW'(k) < r_kc) begin
                        r_lq[k] <= r_kq[k];
                    end else if (r_requeue && !(r_boost[r_id] || r_base[r_id])
                                 && CW'(k) == r_kc) begin
                        r_lq[k] <= r_id;
                    end
                end
                r_out.boosted_count <= 4'(r_bc);
                if (r_requeue) begin
                    r_qd[r_id] <= 1'b1;
                end
                if (r_requeue && (r_boost[r_id] || r_base[r_id])) begin
                    r_hc <= r_hc + r_bc + 1'b1;
                    r_lc <= r_kc;
                end else begin
                    r_hc <= r_hc + r_bc;
                    r_lc <= r_kc + (r_requeue ? CW'(1) : CW'(0));
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/tlps_chk.sv
// Port-level checker of the scheduler, bound to the top level.
`default_nettype none
module tlps_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [9:0]  out_data
);
    // One word in flight: no input taken while a result is pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid) else $error("result too early");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data[5:4] != 2'd3) else $error("bad status code");
endmodule

bind two_level_priority_scheduler_aging_unit tlps_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data (out_ch.data)
);
`default_nettype wire

// File: tb/two_level_priority_scheduler_aging_unit_checker.sv
// Checker that predicts scheduler results from observed requests and compares them.
module two_level_priority_scheduler_aging_unit_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [7:0]  i_cfg_data,
    input  wire        i_in_valid,
    input  wire        i_in_ready,
    input  tlps_pkg::t_in_word  i_in_word,
    input  wire        i_out_valid,
    input  wire        i_out_ready,
    input  tlps_pkg::t_out_word i_out_word,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results_seen,
    output int         o_boost_total
);
    import tlps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = 8;

    logic [2:0] hi_q [NT];
    logic [2:0] lo_q [NT];
    int         hi_n;
    int         lo_n;
    logic [7:0] waits [NT];
    logic       boosted [NT];
    logic       base_hi [NT];
    logic       queued [NT];
    logic [7:0] threshold;
    t_out_word  expected_words [$];

    function automatic t_out_word schedule_word(t_in_word w);
        t_out_word r;
        logic [2:0] id;
        logic [2:0] keep [NT];
        logic [2:0] lift [NT];
        int nk;
        int nb;
        logic requeue;
        r = '0;
        r.status = ST_OK;
        id = w.task_id;
        nk = 0;
        nb = 0;
        if (w.req_type == REQ_ADD) begin
            if (w.priority_req > 2'd1) begin
                r.status = ST_BADPRI;
            end else if (queued[id]) begin
                r.status = ST_QUEUED;
            end else begin
                base_hi[id] = w.priority_req[0];
                boosted[id] = 1'b0;
                queued[id] = 1'b1;
                if (w.priority_req[0]) begin
                    hi_q[hi_n] = id;
                    hi_n++;
                end else begin
                    lo_q[lo_n] = id;
                    lo_n++;
                end
            end
        end else if (hi_n == 0 && lo_n == 0) begin
            r.next_task = id;
            r.next_valid = w.old_valid;
        end else begin
            requeue = w.old_valid;
            if (requeue && queued[id]) begin
                requeue = 1'b0;
                r.status = ST_QUEUED;
            end
            if (hi_n > 0) begin
                r.next_task = hi_q[0];
                for (int i = 0; i < NT - 1; i++) hi_q[i] = hi_q[i+1];
                hi_n--;
            end else begin
                r.next_task = lo_q[0];
                for (int i = 0; i < NT - 1; i++) lo_q[i] = lo_q[i+1];
                lo_n--;
            end
            queued[r.next_task] = 1'b0;
            r.next_valid = 1'b1;
            // Aging compares the count from before this step's increment.
            for (int i = 0; i < lo_n; i++) begin
                logic [2:0] t;
                logic [7:0] prev;
                t = lo_q[i];
                prev = waits[t];
                if (prev != 8'd255) waits[t] = prev + 8'd1;
                if (prev > threshold) begin
                    boosted[t] = 1'b1;
                    lift[nb] = t;
                    nb++;
                end else begin
                    keep[nk] = t;
                    nk++;
                end
            end
            if (nb > 0) begin
                for (int i = NT - 1; i >= 0; i--)
                    if (i >= nb && i - nb < hi_n) hi_q[i] = hi_q[i-nb];
                for (int i = 0; i < nb; i++) hi_q[i] = lift[i];
                hi_n += nb;
            end
            for (int i = 0; i < nk; i++) lo_q[i] = keep[i];
            lo_n = nk;
            r.boosted_count = 4'(nb);
            boosted[r.next_task] = 1'b0;
            waits[r.next_task] = 8'd0;
            if (requeue) begin
                queued[id] = 1'b1;
                if (boosted[id] || base_hi[id]) begin
                    hi_q[hi_n] = id;
                    hi_n++;
                end else begin
                    lo_q[lo_n] = id;
                    lo_n++;
                end
            end
        end
        return r;
    endfunction

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hi_n <= 0;
            lo_n <= 0;
            threshold <= 8'd10;
            for (int i = 0; i < NT; i++) begin
                waits[i] <= '0;
                boosted[i] <= 1'b0;
                base_hi[i] <= 1'b0;
                queued[i] <= 1'b0;
            end
            expected_words.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
            o_boost_total <= 0;
        end else begin
            if (i_cfg_we) threshold = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                o_results_seen <= o_results_seen + 1;
                if (expected_words.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected word %p", i_out_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    t_out_word e;
                    e = expected_words.pop_front();
                    o_boost_total <= o_boost_total + e.boosted_count;
                    if (e.next_task !== i_out_word.next_task
                        || e.next_valid !== i_out_word.next_valid
                        || e.status !== i_out_word.status
                        || e.boosted_count !== i_out_word.boosted_count) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p, got %p", e, i_out_word);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_words.push_back(schedule_word(i_in_word));
        end
    end
endmodule

// File: tb/two_level_priority_scheduler_aging_unit_tb.sv
// Top of the scheduler testbench: clock, reset, request stimulus and verdict.
module two_level_priority_scheduler_aging_unit_tb;
    import tlps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [7:0] i_cfg_data;
    int fail_count;
    int pending;
    int results_seen;
    int boost_total;
    int words_sent;

    tlps_if #(.T(t_in_word))  in_ch ();
    tlps_if #(.T(t_out_word)) out_ch ();

    two_level_priority_scheduler_aging_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    two_level_priority_scheduler_aging_unit_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready), .i_in_word(in_ch.data),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready), .i_out_word(out_ch.data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen), .o_boost_total(boost_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The receiver stalls a random number of cycles before taking each word.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk iff out_ch.valid);
        end
    end

    // Valid stays high after an accept until the next word or an idle call.
    task automatic send_word(input logic rq, input logic [2:0] id,
                             input logic [1:0] pr, input logic ov, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.data <= '{req_type: rq, task_id: id, priority_req: pr, old_valid: ov};
        in_ch.valid <= 1'b1;
        @(posedge i_clk iff in_ch.ready);
        words_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    task automatic drain_and_set(input logic [7:0] value);
        wait_drained();
        repeat (20) @(posedge i_clk);
        i_cfg_data <= value;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [7:0] settings [5];
        int roll;
        bit burst;
        settings = '{8'd0, 8'd254, 8'd2, 8'd10, 8'd5};
        words_sent = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty schedules, bad priorities, duplicates, both levels.
        send_word(REQ_SCHED, 3'd7, 2'd0, 1'b1, 0);
        send_word(REQ_SCHED, 3'd0, 2'd3, 1'b0, 0);
        send_word(REQ_ADD, 3'd0, 2'd2, 1'b0, 0);
        send_word(REQ_ADD, 3'd7, 2'd3, 1'b1, 0);
        for (int i = 0; i < 8; i++) send_word(REQ_ADD, 3'(i), 2'(i % 2), 1'b0, 1);
        send_word(REQ_ADD, 3'd4, 2'd1, 1'b0, 0);
        send_word(REQ_SCHED, 3'd2, 2'd0, 1'b1, 0);
        send_word(REQ_SCHED, 3'd1, 2'd0, 1'b1, 0);
        send_word(REQ_SCHED, 3'd5, 2'd0, 1'b0, 1);
        for (int i = 0; i < 9; i++) send_word(REQ_SCHED, 3'd0, 2'd0, 1'b0, 0);

        for (int phase = 0; phase < 5; phase++) begin
            drain_and_set(settings[phase]);
            for (int n = 0; n < 400; n++) begin
                // Some stretches run back to back with no sender gaps.
                burst = (n % 100) < 20;
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    send_word(REQ_ADD, 3'($urandom), ($urandom_range(0, 9) == 0)
                              ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1)),
                              1'($urandom), burst);
                else
                    send_word(REQ_SCHED, 3'($urandom), 2'($urandom),
                              ($urandom_range(0, 4) != 0), burst);
                if (n == 200) wait_drained();
            end
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        $display("Sent %0d requests over five threshold settings, checked %0d results.",
                 words_sent, results_seen);
        $display("Results reported %0d aging boosts in total.", boost_total);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// File: two_level_priority_scheduler_aging_unit.f
rtl/core/tlps_pkg.sv
rtl/core/tlps_if.sv
rtl/core/tlps_ctrl.sv
rtl/core/tlps_dp.sv
rtl/core/two_level_priority_scheduler_aging_unit.sv
rtl/core/tlps_chk.sv
tb/two_level_priority_scheduler_aging_unit_checker.sv
tb/two_level_priority_scheduler_aging_unit_tb.sv
